>>> hw/rtl/mmf_pkg.sv
// Types, constants and the status length table shared by the MIDI message framer.
`default_nettype none

package mmf_pkg;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [3:0] HI_STATUS   = 4'h8;
    localparam logic [3:0] HI_PROGRAM  = 4'hC;
    localparam logic [3:0] HI_PRESSURE = 4'hD;
    localparam logic [3:0] HI_SYSTEM   = 4'hF;

    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_SYSEX = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_SHORT = 2'd1,
        MODE_SYSEX = 2'd2
    } mode_t;

    // One queued result; unused data bytes are masked at the output stage.
    typedef struct packed {
        logic       kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] count;
        logic       last;
    } msg_rec_t;

    function automatic logic [1:0] msg_length(input logic [7:0] s);
        logic [1:0] len;
        len = LEN_NONE;
        if (s[7:4] < HI_STATUS)
        begin
            len = LEN_NONE;
        end
        else if (s[7:4] == HI_PROGRAM || s[7:4] == HI_PRESSURE)
        begin
            len = LEN_TWO;
        end
        else if (s[7:4] != HI_SYSTEM)
        begin
            len = LEN_THREE;
        end
        else
        begin
            case (s[3:0])
                4'h1, 4'h3:                      len = LEN_TWO;
                4'h2:                            len = LEN_THREE;
                4'h6, 4'h8, 4'hA, 4'hB,
                4'hC, 4'hE, 4'hF:                len = LEN_ONE;
                default:                         len = LEN_NONE;
            endcase
        end
        return len;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mmf_byte_if.sv
// Input channel: one raw MIDI byte per beat.
`default_nettype none

interface mmf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mmf_msg_if.sv
// Output channel: one framed message or sysex byte per beat.
`default_nettype none

interface mmf_msg_if;
    logic       valid;
    logic       ready;
    logic       message_kind;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic [1:0] byte_count;
    logic       end_of_message;

    modport source (output valid, output message_kind, output first_byte,
                    output second_byte, output third_byte, output byte_count,
                    output end_of_message, input ready);
    modport sink   (input valid, input message_kind, input first_byte,
                    input second_byte, input third_byte, input byte_count,
                    input end_of_message, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mmf_front.sv
// Front end: takes bytes, classifies them and tracks the framing state.
`default_nettype none

module mmf_front (
    input  wire logic      clk,
    input  wire logic      rst_n,
    mmf_byte_if.sink       byte_in,
    input  wire logic      full,
    output logic           push,
    output mmf_pkg::msg_rec_t rec
);

    mmf_pkg::mode_t mode_reg, mode_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] held_reg, held_next;
    logic [1:0] expected_reg, expected_next;
    logic [1:0] taken_reg, taken_next;

    logic       take;
    logic [7:0] b;
    logic [1:0] len;
    logic [1:0] taken_inc;

    assign byte_in.ready = !full;
    assign take          = byte_in.valid && !full;
    assign b             = byte_in.data_byte;
    assign len           = mmf_pkg::msg_length(b);
    assign taken_inc     = taken_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= mmf_pkg::MODE_IDLE;
            status_reg   <= '0;
            held_reg     <= '0;
            expected_reg <= '0;
            taken_reg    <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            status_reg   <= status_next;
            held_reg     <= held_next;
            expected_reg <= expected_next;
            taken_reg    <= taken_next;
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        status_next   = status_reg;
        held_next     = held_reg;
        expected_next = expected_reg;
        taken_next    = taken_reg;
        push          = 1'b0;
        rec.kind      = mmf_pkg::KIND_SHORT;
        rec.b0        = b;
        rec.b1        = b;
        rec.b2        = b;
        rec.count     = mmf_pkg::LEN_ONE;
        rec.last      = 1'b1;
        case (mode_reg)
            mmf_pkg::MODE_SYSEX:
            begin
                rec.kind = mmf_pkg::KIND_SYSEX;
                rec.last = (b == mmf_pkg::SYSEX_END);
                push     = take;
                if (take && rec.last)
                begin
                    mode_next = mmf_pkg::MODE_IDLE;
                end
            end
            mmf_pkg::MODE_SHORT:
            begin
                rec.b0 = status_reg;
                if (expected_reg == mmf_pkg::LEN_THREE)
                begin
                    rec.b1    = held_reg;
                    rec.count = mmf_pkg::LEN_THREE;
                end
                else
                begin
                    rec.count = mmf_pkg::LEN_TWO;
                end
                if (take)
                begin
                    taken_next = taken_inc;
                    if (taken_inc >= expected_reg)
                    begin
                        push      = 1'b1;
                        mode_next = mmf_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        held_next = b;
                    end
                end
            end
            default:
            begin
                if (take)
                begin
                    mode_next = mmf_pkg::MODE_IDLE;
                    if (b == mmf_pkg::SYSEX_START)
                    begin
                        rec.kind  = mmf_pkg::KIND_SYSEX;
                        rec.last  = 1'b0;
                        push      = 1'b1;
                        mode_next = mmf_pkg::MODE_SYSEX;
                    end
                    else if (len == mmf_pkg::LEN_ONE)
                    begin
                        push = 1'b1;
                    end
                    else if (len != mmf_pkg::LEN_NONE)
                    begin
                        mode_next     = mmf_pkg::MODE_SHORT;
                        status_next   = b;
                        held_next     = '0;
                        expected_next = len;
                        taken_next    = 2'd1;
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/mmf_queue.sv
// Small FIFO of framed results between the front end and the output stage.
`default_nettype none

module mmf_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire mmf_pkg::msg_rec_t push_rec,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output mmf_pkg::msg_rec_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    mmf_pkg::msg_rec_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/mmf_back.sv
// Output stage: formats queued results and holds them until the sink takes the beat.
`default_nettype none

module mmf_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              not_empty,
    input  wire mmf_pkg::msg_rec_t head,
    output logic                   pop,
    mmf_msg_if.source              msg_out
);

    logic       valid_reg;
    logic       kind_reg;
    logic [7:0] b0_reg;
    logic [7:0] b1_reg;
    logic [7:0] b2_reg;
    logic [1:0] count_reg;
    logic       last_reg;

    assign pop = not_empty && (!valid_reg || msg_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (msg_out.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Unused data bytes read as zero.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= head.kind;
            b0_reg    <= head.b0;
            b1_reg    <= (head.count >= mmf_pkg::LEN_TWO) ? head.b1 : 8'h00;
            b2_reg    <= (head.count == mmf_pkg::LEN_THREE) ? head.b2 : 8'h00;
            count_reg <= head.count;
            last_reg  <= head.last;
        end
    end

    assign msg_out.valid          = valid_reg;
    assign msg_out.message_kind   = kind_reg;
    assign msg_out.first_byte     = b0_reg;
    assign msg_out.second_byte    = b1_reg;
    assign msg_out.third_byte     = b2_reg;
    assign msg_out.byte_count     = count_reg;
    assign msg_out.end_of_message = last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/midi_message_framer.sv
// Top level of the MIDI message framer: front end, result queue and output stage.
//
//   channel   dir  beat payload
//   byte_in   in   data_byte[7:0]
//   msg_out   out  message_kind, first/second/third_byte, byte_count, end_of_message
//
// One byte is taken per cycle whenever the result queue has room.
// A result passes through a queue entry and then the output register before it reaches msg_out.
// Output register and queue decouple the sides; byte_in stalls only when the queue is full.
// Reset (rst_n low) returns the framer to idle and empties the queue and output stage.
`default_nettype none

module midi_message_framer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mmf_byte_if.sink  byte_in,
    mmf_msg_if.source msg_out
);

    mmf_pkg::msg_rec_t push_rec;
    mmf_pkg::msg_rec_t head;
    logic push, full, pop, not_empty;

    mmf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .full    (full),
        .push    (push),
        .rec     (push_rec)
    );

    mmf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    mmf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .msg_out   (msg_out)
    );

endmodule

`default_nettype wire
